[hw/rtl/sfcp_pkg.sv]
// ----------------------------------------------------------------------------
// sfcp_pkg
// Shared widths, reset values, register indexes and types of the sync frame
// chain probe.
// ----------------------------------------------------------------------------
package sfcp_pkg;

  // Stream positions and counters
  localparam int unsigned PosW     = 24;
  localparam int unsigned CntW     = 16;
  localparam int unsigned AddW     = PosW + 1;

  // Byte window: eight bytes, newest in the low byte
  localparam int unsigned WinBytes = 8;
  localparam int unsigned WinW     = WinBytes * 8;
  localparam int unsigned HeadLsb  = WinW - 16;
  localparam int unsigned LenW     = 12;
  localparam int unsigned SyncW    = 32;

  // Window fill count, 0 .. WinBytes
  localparam int unsigned FillW    = 4;
  localparam logic [FillW-1:0] FillFull = FillW'(WinBytes);

  // Port widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OutCntW  = 16;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  // Register reset values
  localparam logic [SyncW-1:0] SyncWordRst = 32'hF872_6FBB;
  localparam logic [ThrW-1:0]  ValidThrRst = 16'd100;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegSyncWord = 1'b0,
    RegValidThr = 1'b1
  } sfcp_reg_e;

  // Configuration as seen by the core
  typedef struct packed {
    logic [SyncW-1:0] sync_word;
    logic [ThrW-1:0]  valid_thr;
  } sfcp_cfg_t;

  // One result per byte
  typedef struct packed {
    logic               window_full;
    logic [OutCntW-1:0] frames_seen;
    logic [OutCntW-1:0] valid_score;
    logic               detected;
  } sfcp_res_t;

endpackage

[hw/rtl/sync_frame_chain_probe.sv]
// ----------------------------------------------------------------------------
// sync_frame_chain_probe
// Byte-serial sync-word chain detector with stream request ports.
// ----------------------------------------------------------------------------
// Takes one byte per clock unless the result side stalls and returns exactly
// one result per byte, via the input and result registers. A byte whose
// tuser bit is set starts a new buffer and clears all probe state first.
// Once eight bytes of a buffer are in, each byte judges the window position
// of its oldest byte: a sync word at window offset four counts a frame, and
// a frame that starts exactly where the previous span ended adds one plus
// an eighth of the subframes to the valid score. Counts saturate. The
// sustained rate is one byte per clock without back-pressure, set by the
// state update loop in the core; there is no clearing pass after reset.
// Registers: index 0 sync word (reset 0xF8726FBB), index 1 valid threshold
// (reset 100). Write them only while no request is in flight.
// ----------------------------------------------------------------------------
module sync_frame_chain_probe (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input request side
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sfcp_pkg::ByteW-1:0]       s_axis_tdata,  // [7:0] data_byte
  input  logic                             s_axis_tuser,  // [0] buffer_start
  // Result side
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sfcp_pkg::OutDataW-1:0]    m_axis_tdata,  // [15:0] frames_seen,
                                                          // [31:16] valid_score,
                                                          // [32] detected
  output logic                             m_axis_tuser,  // [0] window_full
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [sfcp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sfcp_pkg::CfgDataW-1:0]    cfg_data_i
);
  import sfcp_pkg::*;

  sfcp_cfg_t        cfg;
  sfcp_res_t        res;
  sfcp_res_t        res_q;
  logic             in_valid_q;
  logic [ByteW-1:0] data_q;
  logic             start_q;
  logic             out_valid_q;
  logic             advance;

  // Move the held request on when the result register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  sfcp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sfcp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .data_byte_i    (data_q),
    .buffer_start_i (start_q),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  // Track occupancy of the input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the request and the result payloads
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      data_q  <= s_axis_tdata;
      start_q <= s_axis_tuser;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.window_full;
  assign m_axis_tdata  = {{(OutDataW - 2*OutCntW - 1){1'b0}}, res_q.detected,
                          res_q.valid_score, res_q.frames_seen};

`ifndef SYNTHESIS
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("held request dropped before reaching the core");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input side stalled with an empty input register");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("stepped request left no result");
`endif

endmodule

[hw/rtl/sfcp_cfg.sv]
// ----------------------------------------------------------------------------
// sfcp_cfg
// Configuration registers: sync word and detection threshold, written
// through a plain write port.
// ----------------------------------------------------------------------------
module sfcp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfcp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfcp_pkg::CfgDataW-1:0]  cfg_data_i,
  output sfcp_pkg::sfcp_cfg_t            cfg_o
);
  import sfcp_pkg::*;

  logic [SyncW-1:0] sync_word_q;
  logic [ThrW-1:0]  valid_thr_q;

  // Take a write at the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= SyncWordRst;
      valid_thr_q <= ValidThrRst;
    end else if (cfg_we_i) begin
      case (sfcp_reg_e'(cfg_idx_i))
        RegSyncWord: sync_word_q <= cfg_data_i[SyncW-1:0];
        RegValidThr: valid_thr_q <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.sync_word = sync_word_q;
  assign cfg_o.valid_thr = valid_thr_q;

endmodule

[hw/rtl/sfcp_core.sv]
// ----------------------------------------------------------------------------
// sfcp_core
// Per-byte probe state and judge: shifts a byte into the window, judges the
// oldest window position for a sync hit or a subframe at the span end and
// updates the saturating counts. State moves on each step request.
// ----------------------------------------------------------------------------
module sfcp_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [sfcp_pkg::ByteW-1:0]  data_byte_i,
  input  logic                        buffer_start_i,
  input  sfcp_pkg::sfcp_cfg_t         cfg_i,
  output sfcp_pkg::sfcp_res_t         res_o
);
  import sfcp_pkg::*;

  // Probe state
  logic [WinW-1:0]  win_q,    win_b,    win_d;
  logic [PosW-1:0]  pos_q,    pos_b,    pos_d;
  logic [PosW-1:0]  last_q,   last_b,   last_d;
  logic [PosW-1:0]  span_q,   span_b,   span_d;
  logic [PosW-1:0]  sub_q,    sub_b,    sub_d;
  logic [CntW-1:0]  frames_q, frames_b, frames_d;
  logic [CntW-1:0]  valid_q,  valid_b,  valid_d;
  logic [FillW-1:0] fill_q,   fill_b,   fill_d;

  // Judge terms
  logic             full;
  logic             hit;
  logic             chain;
  logic             at_end;
  logic [PosW-1:0]  jpos;
  logic [PosW-1:0]  len2;
  logic [CntW:0]    frames_sum;
  logic [AddW-1:0]  valid_sum;
  logic [PosW:0]    span_sum;
  logic [PosW:0]    sub_sum;

  // Start of a buffer judges against cleared state
  always_comb begin
    win_b    = buffer_start_i ? '0 : win_q;
    pos_b    = buffer_start_i ? '0 : pos_q;
    last_b   = buffer_start_i ? '0 : last_q;
    span_b   = buffer_start_i ? '0 : span_q;
    sub_b    = buffer_start_i ? '0 : sub_q;
    frames_b = buffer_start_i ? '0 : frames_q;
    valid_b  = buffer_start_i ? '0 : valid_q;
    fill_b   = buffer_start_i ? '0 : fill_q;
  end

  // Shift the byte in and find the judged position
  assign win_d  = {win_b[WinW-ByteW-1:0], data_byte_i};
  assign pos_d  = pos_b + PosW'(1);
  assign fill_d = (fill_b < FillFull) ? fill_b + FillW'(1) : fill_b;
  assign full   = (fill_d == FillFull);
  assign jpos   = pos_d - PosW'(WinBytes);
  assign len2   = PosW'({win_d[HeadLsb+LenW-1:HeadLsb], 1'b0});

  // Sync hit, chained hit and span end, all modulo the position width
  assign hit    = full && (win_d[SyncW-1:0] == cfg_i.sync_word);
  assign chain  = (PosW'(last_b + span_b) == jpos);
  assign at_end = (PosW'(jpos - last_b) == span_b);

  // Widened sums for saturation
  assign frames_sum = {1'b0, frames_b} + (CntW+1)'(1);
  assign valid_sum  = AddW'(valid_b) + AddW'(sub_b >> 3) + AddW'(1);
  assign span_sum   = {1'b0, span_b} + {1'b0, len2};
  assign sub_sum    = {1'b0, sub_b} + (PosW+1)'(1);

  // Update frame, chain and subframe state
  always_comb begin
    last_d   = last_b;
    span_d   = span_b;
    sub_d    = sub_b;
    frames_d = frames_b;
    valid_d  = valid_b;
    if (hit) begin
      frames_d = frames_sum[CntW] ? '1 : frames_sum[CntW-1:0];
      if (chain) begin
        valid_d = (|valid_sum[AddW-1:CntW]) ? '1 : valid_sum[CntW-1:0];
      end
      sub_d  = '0;
      last_d = jpos;
      span_d = len2;
    end else if (full && at_end) begin
      sub_d  = sub_sum[PosW] ? '1 : sub_sum[PosW-1:0];
      span_d = span_sum[PosW] ? '1 : span_sum[PosW-1:0];
    end
  end

  // Hold state, advance on a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      pos_q    <= '0;
      last_q   <= '0;
      span_q   <= '0;
      sub_q    <= '0;
      frames_q <= '0;
      valid_q  <= '0;
      fill_q   <= '0;
    end else if (step_i) begin
      win_q    <= win_d;
      pos_q    <= pos_d;
      last_q   <= last_d;
      span_q   <= span_d;
      sub_q    <= sub_d;
      frames_q <= frames_d;
      valid_q  <= valid_d;
      fill_q   <= fill_d;
    end
  end

  // Result for this byte, from the updated counts
  assign res_o.window_full = full;
  assign res_o.frames_seen = frames_d[OutCntW-1:0];
  assign res_o.valid_score = valid_d[OutCntW-1:0];
  assign res_o.detected    = (valid_d >= cfg_i.valid_thr);

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("window fill count beyond window size");

  a_frames_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !buffer_start_i |=> frames_q >= $past(frames_q))
    else $error("frame count went down without a buffer start");

  a_valid_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !buffer_start_i && !hit |=> valid_q == $past(valid_q))
    else $error("valid score moved without a sync hit");
`endif

endmodule
